@@ src/tbgd_pkg.sv @@
`timescale 1ns / 1ps

package tbgd_pkg;

   localparam int TICK_BITS_DEFAULT   = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENABLE       = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOUBLE_CLICK = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG         = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXTRA_LONG   = 3'd4;

   localparam logic [15:0] DEBOUNCE_RESET     = 16'd20;
   localparam logic [15:0] DOUBLE_CLICK_RESET = 16'd250;
   localparam logic [15:0] LONG_RESET         = 16'd600;
   localparam logic [15:0] EXTRA_LONG_RESET   = 16'd1200;

   typedef enum logic [2:0] {
      KEY_OK    = 3'd0,
      KEY_LEFT  = 3'd1,
      KEY_RIGHT = 3'd2,
      KEY_UP    = 3'd3,
      KEY_DOWN  = 3'd4,
      KEY_BACK  = 3'd5
   } key_type;

   typedef enum logic [1:0] {
      EV_PRESS   = 2'd0,
      EV_SHORT   = 2'd1,
      EV_LONG    = 2'd2,
      EV_RELEASE = 2'd3
   } evt_type;

   typedef struct packed {
      logic        first_button_raw;
      logic        second_button_raw;
      logic [31:0] now_tick;
   } req_type;

   typedef struct packed {
      logic [2:0]  key_code;
      logic [1:0]  event_type;
      logic [31:0] sequence_number;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic        enable;
      logic [15:0] debounce_ticks;
      logic [15:0] double_click_ticks;
      logic [15:0] hold_ticks;
      logic [15:0] extra_hold_ticks;
   } cfg_type;

   // up to two gestures per sample: button one first, then button two
   typedef struct packed {
      logic    one_valid;
      key_type one_key;
      logic    two_valid;
      key_type two_key;
      evt_type two_middle;
   } job_type;

endpackage

@@ src/two_button_gesture_decoder_core.sv @@
`timescale 1ns / 1ps
// Two-button gesture decoder: debounce, tap, double click and long holds.
// req channel: one poll sample per beat (two raw button levels, tick count).
//   A sample is taken whenever req_valid is high and req_stall is low; req_stall rises only when the job queue
//   between the classifier and the event serializer is full.
// rsp channel: one event per beat (key, press/short/long/release, running
//   sequence number, last_of_run on the final event of a sample).
// A sample yields zero, three or six events. Its job is written into the queue,
//   then the serializer moves it into the output register, giving one event a
//   cycle while rsp_stall is low.
// rsp_stall holds the current event in the output register; samples keep
//   being taken until the queue fills.
// csr port: write-only, csr_index selects enable, debounce, double click,
//   long and extra-long thresholds. Write only while idle.
// Reset (synchronous): thresholds to 20/250/600/1200 ticks, block disabled,
//   all button state, queue and sequence count cleared.
module two_button_gesture_decoder_core
   import tbgd_pkg::*;
#(
   parameter int TICK_BITS   = TICK_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   cfg_type cfg_ff;
   logic    q_full;
   logic    q_push;
   job_type push_job;
   logic    q_pop;
   logic    q_empty;
   job_type head_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable             <= 1'b0;
         cfg_ff.debounce_ticks     <= DEBOUNCE_RESET;
         cfg_ff.double_click_ticks <= DOUBLE_CLICK_RESET;
         cfg_ff.hold_ticks         <= LONG_RESET;
         cfg_ff.extra_hold_ticks   <= EXTRA_LONG_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ENABLE:       cfg_ff.enable             <= csr_data[0];
            CSR_DEBOUNCE:     cfg_ff.debounce_ticks     <= csr_data;
            CSR_DOUBLE_CLICK: cfg_ff.double_click_ticks <= csr_data;
            CSR_LONG:         cfg_ff.hold_ticks         <= csr_data;
            CSR_EXTRA_LONG:   cfg_ff.extra_hold_ticks   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   tbgd_front #(.TICK_BITS(TICK_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   tbgd_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_job (head_job)
   );

   tbgd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_job     (head_job),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ src/tbgd_debounce.sv @@
`timescale 1ns / 1ps

module tbgd_debounce
   import tbgd_pkg::*;
#(
   parameter int TICK_BITS = TICK_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 raw,
   input  logic [TICK_BITS-1:0] now,
   input  logic [15:0]          debounce_ticks,
   output logic                 fire,
   output logic                 level
);

   logic                 pressed_ff;
   logic                 raw_last_ff;
   logic [TICK_BITS-1:0] changed_at_ff;
   logic                 changed;
   logic [TICK_BITS-1:0] stable_for;

   assign changed    = raw != raw_last_ff;
   assign stable_for = now - changed_at_ff;
   assign fire       = step && !changed && (raw != pressed_ff) &&
                       (stable_for >= TICK_BITS'(debounce_ticks));
   assign level      = fire ? raw : pressed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff    <= 1'b0;
         raw_last_ff   <= 1'b0;
         changed_at_ff <= '0;
      end else if (step) begin
         if (changed) begin
            raw_last_ff   <= raw;
            changed_at_ff <= now;
         end
         if (fire) begin
            pressed_ff <= raw;
         end
      end
   end

endmodule

@@ src/tbgd_front.sv @@
`timescale 1ns / 1ps

module tbgd_front
   import tbgd_pkg::*;
#(
   parameter int TICK_BITS = TICK_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    req_stall,
   input  logic    q_full,
   output logic    q_push,
   output job_type q_job
);

   logic                 accept;
   logic                 step;
   logic [TICK_BITS-1:0] now;
   logic [TICK_BITS-1:0] long_th;
   logic [TICK_BITS-1:0] extra_th;
   logic [TICK_BITS-1:0] dclick_th;

   logic one_fire, one_level;
   logic two_fire, two_level;

   logic [TICK_BITS-1:0] one_press_start_ff, one_press_start_in;
   logic                 one_right_sent_ff, one_right_sent_in;
   logic [TICK_BITS-1:0] two_press_start_ff, two_press_start_in;
   logic                 two_waiting_ff, two_waiting_in;
   logic [TICK_BITS-1:0] two_first_release_ff, two_first_release_in;
   logic                 two_long_sent_ff, two_long_sent_in;
   logic                 two_extra_sent_ff, two_extra_sent_in;

   logic [TICK_BITS-1:0] one_held;
   logic [TICK_BITS-1:0] two_held;
   logic [TICK_BITS-1:0] since_release;
   logic [TICK_BITS-1:0] since_release_in;
   job_type              job;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;
   assign step      = accept && cfg.enable;
   assign now       = TICK_BITS'(req_data.now_tick);
   assign long_th   = TICK_BITS'(cfg.hold_ticks);
   assign extra_th  = TICK_BITS'(cfg.extra_hold_ticks);
   assign dclick_th = TICK_BITS'(cfg.double_click_ticks);

   tbgd_debounce #(.TICK_BITS(TICK_BITS)) u_deb_one (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .raw            (req_data.first_button_raw),
      .now            (now),
      .debounce_ticks (cfg.debounce_ticks),
      .fire           (one_fire),
      .level          (one_level)
   );

   tbgd_debounce #(.TICK_BITS(TICK_BITS)) u_deb_two (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .raw            (req_data.second_button_raw),
      .now            (now),
      .debounce_ticks (cfg.debounce_ticks),
      .fire           (two_fire),
      .level          (two_level)
   );

   assign one_held      = now - one_press_start_ff;
   assign two_held      = now - two_press_start_ff;
   assign since_release = now - two_first_release_ff;

   always_comb begin
      one_press_start_in   = one_press_start_ff;
      one_right_sent_in    = one_right_sent_ff;
      two_press_start_in   = two_press_start_ff;
      two_waiting_in       = two_waiting_ff;
      two_first_release_in = two_first_release_ff;
      two_long_sent_in     = two_long_sent_ff;
      two_extra_sent_in    = two_extra_sent_ff;
      job.one_valid  = 1'b0;
      job.one_key    = KEY_OK;
      job.two_valid  = 1'b0;
      job.two_key    = KEY_DOWN;
      job.two_middle = EV_SHORT;

      // button one
      if (one_fire) begin
         if (one_level) begin
            one_press_start_in = now;
            one_right_sent_in  = 1'b0;
         end else if (!one_right_sent_ff) begin
            job.one_valid = 1'b1;
            job.one_key   = (one_held >= long_th) ? KEY_LEFT : KEY_OK;
         end
      end else if (one_level) begin
         if (!one_right_sent_ff && one_held >= extra_th) begin
            one_right_sent_in = 1'b1;
            job.one_valid     = 1'b1;
            job.one_key       = KEY_RIGHT;
         end
      end

      // button two
      if (two_fire) begin
         if (two_level) begin
            two_press_start_in = now;
            two_long_sent_in   = 1'b0;
            two_extra_sent_in  = 1'b0;
         end else if (!two_long_sent_ff) begin
            if (two_waiting_ff && since_release <= dclick_th) begin
               job.two_valid  = 1'b1;
               job.two_key    = KEY_UP;
               two_waiting_in = 1'b0;
            end else begin
               two_waiting_in       = 1'b1;
               two_first_release_in = now;
            end
         end else begin
            two_waiting_in = 1'b0;
         end
      end else if (two_level) begin
         if (!two_long_sent_ff && two_held >= long_th) begin
            two_long_sent_in = 1'b1;
            two_waiting_in   = 1'b0;
            job.two_valid    = 1'b1;
            job.two_key      = KEY_BACK;
         end else if (two_long_sent_ff && !two_extra_sent_ff && two_held >= extra_th) begin
            two_extra_sent_in = 1'b1;
            job.two_valid     = 1'b1;
            job.two_key       = KEY_BACK;
            job.two_middle    = EV_LONG;
         end
      end

      // single click confirmed once the window has closed
      since_release_in = now - two_first_release_in;
      if (!two_level && two_waiting_in && since_release_in > dclick_th) begin
         job.two_valid  = 1'b1;
         job.two_key    = KEY_DOWN;
         job.two_middle = EV_SHORT;
         two_waiting_in = 1'b0;
      end
   end

   assign q_push = step && (job.one_valid || job.two_valid);
   assign q_job  = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         one_press_start_ff   <= '0;
         one_right_sent_ff    <= 1'b0;
         two_press_start_ff   <= '0;
         two_waiting_ff       <= 1'b0;
         two_first_release_ff <= '0;
         two_long_sent_ff     <= 1'b0;
         two_extra_sent_ff    <= 1'b0;
      end else if (step) begin
         one_press_start_ff   <= one_press_start_in;
         one_right_sent_ff    <= one_right_sent_in;
         two_press_start_ff   <= two_press_start_in;
         two_waiting_ff       <= two_waiting_in;
         two_first_release_ff <= two_first_release_in;
         two_long_sent_ff     <= two_long_sent_in;
         two_extra_sent_ff    <= two_extra_sent_in;
      end
   end

endmodule

@@ src/tbgd_queue.sv @@
`timescale 1ns / 1ps

module tbgd_queue
   import tbgd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type head_job
);

   localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0]   LAST_PTR   = PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(QUEUE_DEPTH);

   job_type                entries_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff;
   logic [PTR_BITS-1:0]    rd_ptr_ff;
   logic [COUNT_BITS-1:0]  count_ff;
   logic                   do_push;
   logic                   do_pop;

   function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
      next_ptr = (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   assign full     = count_ff == FULL_COUNT;
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

@@ src/tbgd_back.sv @@
`timescale 1ns / 1ps

module tbgd_back
   import tbgd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  job_type q_job,
   output logic    q_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   logic [31:0] seq_ff;
   logic        second_ff;
   logic [1:0]  beat_ff;

   logic        advance;
   logic        use_two;
   logic        last;
   key_type     key;
   evt_type     kind;

   assign advance = !q_empty && (!rsp_valid_ff || !rsp_stall);
   assign use_two = second_ff || !q_job.one_valid;
   assign key     = use_two ? q_job.two_key : q_job.one_key;
   assign last    = (beat_ff == 2'd2) && (use_two || !q_job.two_valid);
   assign q_pop   = advance && last;

   always_comb begin
      case (beat_ff)
         2'd0:    kind = EV_PRESS;
         2'd1:    kind = use_two ? q_job.two_middle : EV_SHORT;
         default: kind = EV_RELEASE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff.key_code        <= key;
         rsp_data_ff.event_type      <= kind;
         rsp_data_ff.sequence_number <= seq_ff + 32'd1;
         rsp_data_ff.last_of_run     <= last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         seq_ff       <= '0;
         second_ff    <= 1'b0;
         beat_ff      <= '0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            seq_ff       <= seq_ff + 32'd1;
            if (last) begin
               second_ff <= 1'b0;
               beat_ff   <= '0;
            end else if (beat_ff == 2'd2) begin
               second_ff <= 1'b1;
               beat_ff   <= '0;
            end else begin
               beat_ff <= beat_ff + 2'd1;
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
